// ----- rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  // field and store widths
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int CURSOR_W    = 11;
  localparam int BYTE_W      = 8;
  localparam int CELL_DATA_W = 2 * BYTE_W;

  // character codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BLANK   = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ERROR   = 8'h45;

  // register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_ATTR = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ERROR_ATTR   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BS_MIN_COL   = 2'd2;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_BLANK,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] attr;
    logic              use_position;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } in_item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_cell;
    logic                out_of_range;
    logic                scrolled;
    logic [BYTE_W-1:0]   read_char;
    logic [BYTE_W-1:0]   read_attr;
  } out_item_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [BYTE_W-1:0]    value;
  } cfg_wr_t;

  // linear cell index of a row and column
  function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    return CELL_W'(CELL_W'(r) * CELL_W'(COLS) + CELL_W'(c));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tcw_if.sv -----
`default_nettype none

// command channel
interface tcw_req_if;
  logic             valid;
  logic             ready;
  tcw_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface tcw_rsp_if;
  logic               valid;
  logic               ready;
  tcw_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// register write channel
interface tcw_cfg_if;
  logic             valid;
  logic             ready;
  tcw_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
`default_nettype none

module tcw_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// Text console writer: a screen store of character/attribute cells plus a cursor.
// Channels: req carries one command per transfer (put, guarded backspace, clear,
// read cell); rsp returns exactly one result per command, in order; cfg writes
// default_attr, error_attr and backspace_min_col and is always ready.
// Timing: the req transfer edge issues the screen read; in the execute state a put
// or backspace writes the cell and updates the cursor, and the result of a put,
// backspace or read is loaded when the output register is free. A put that goes
// past the last row scrolls: the copy walks the screen memory up one row (S_SCROLL),
// the last row is filled with blanks (S_BLANK) and S_RESP loads the result. A clear
// walks all CELLS entries in S_BLANK before S_RESP. These walks are serial, as the
// screen memory has a single write port. req is ready only in the idle state, so a
// new command is taken only after the previous one has executed.
// Reset clears the cursor to cell 0 and loads the register defaults; the screen
// contents are undefined until written (issue a clear first).
// When the receiver stalls, the result stays in the output register; one more
// command is taken and executed, and its result waits in a holding register
// until the output register frees, with req not ready meanwhile.
`default_nettype none

module text_console_writer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcw_req_if.sink    req,
  tcw_rsp_if.source  rsp,
  tcw_cfg_if.sink    cfg
);

  tcw_pkg::state_e state_q, state_d;

  // configuration registers
  logic [tcw_pkg::BYTE_W-1:0] def_attr_q, err_attr_q;
  logic [tcw_pkg::COL_W-1:0]  bs_min_q;

  // cursor as row and column
  logic [tcw_pkg::ROW_W-1:0] crow_q, crow_d;
  logic [tcw_pkg::COL_W-1:0] ccol_q, ccol_d;

  // walk counter for scroll and blank fill
  logic [tcw_pkg::CELL_W-1:0] cnt_q, cnt_d;

  // captured command
  tcw_pkg::in_item_t          item_q;
  logic [tcw_pkg::ROW_W-1:0]  prow_q;
  logic [tcw_pkg::COL_W-1:0]  pcol_q;
  logic [tcw_pkg::CELL_W-1:0] pos_q;
  logic                       oor_q;

  // result holding and output registers
  tcw_pkg::out_item_t res_q, res_d;
  tcw_pkg::out_item_t out_q;
  logic               out_valid_q;
  logic               load_out;
  logic               out_free;

  // screen memory ports
  logic                            mem_we, mem_re;
  logic [tcw_pkg::CELL_W-1:0]      mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_DATA_W-1:0] mem_wdata, mem_rdata;

  // accept-side position decode
  logic                       in_given, in_oor, in_accept;
  logic [tcw_pkg::ROW_W-1:0]  in_row;
  logic [tcw_pkg::COL_W-1:0]  in_col;
  logic [tcw_pkg::CELL_W-1:0] in_cell;

  // execute-side helpers
  logic [tcw_pkg::BYTE_W-1:0] attr_sel;
  logic [tcw_pkg::ROW_W-1:0]  nrow;
  logic [tcw_pkg::COL_W-1:0]  ncol;
  logic                       adv_row, do_scroll;
  logic [tcw_pkg::ROW_W-1:0]  bs_row;
  logic [tcw_pkg::COL_W-1:0]  bs_col;
  logic                       bs_act;

  assign req.ready = (state_q == tcw_pkg::S_IDLE);
  assign in_accept = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid_q;
  assign rsp.data  = out_q;
  assign out_free  = !out_valid_q || rsp.ready;

  // position of an incoming command
  always_comb begin
    in_given = req.data.use_position &&
               (req.data.op == tcw_pkg::OP_PUT || req.data.op == tcw_pkg::OP_READ);
    in_oor   = in_given &&
               (({1'b0, req.data.col} >= (tcw_pkg::COL_W + 1)'(tcw_pkg::COLS)) ||
                ({1'b0, req.data.row} >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)));
    in_row   = in_given ? req.data.row : crow_q;
    in_col   = in_given ? req.data.col : ccol_q;
    in_cell  = tcw_pkg::cell_of(in_row, in_col);
  end

  // put advance and backspace target
  always_comb begin
    attr_sel = (item_q.attr != '0) ? item_q.attr : def_attr_q;
    adv_row  = 1'b0;
    nrow     = prow_q;
    ncol     = pcol_q;
    if (item_q.char_code == tcw_pkg::CH_NEWLINE) begin
      adv_row = 1'b1;
      ncol    = '0;
    end else if (item_q.char_code != tcw_pkg::CH_BLANK) begin
      if (pcol_q == tcw_pkg::COL_W'(tcw_pkg::COLS - 1)) begin
        adv_row = 1'b1;
        ncol    = '0;
      end else begin
        ncol = pcol_q + 1'b1;
      end
    end
    do_scroll = adv_row && (prow_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    if (adv_row && !do_scroll) begin
      nrow = prow_q + 1'b1;
    end

    if (ccol_q == '0) begin
      bs_col = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
      bs_row = crow_q - 1'b1;
    end else begin
      bs_col = ccol_q - 1'b1;
      bs_row = crow_q;
    end
    bs_act = !(crow_q == '0 && ccol_q == '0) && (bs_col >= bs_min_q);
  end

  // sequencer: next state, memory accesses and result
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    crow_d    = crow_q;
    ccol_d    = ccol_q;
    res_d     = res_q;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = in_accept;
    mem_raddr = in_cell;

    unique case (state_q)
      tcw_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = tcw_pkg::S_EXEC;
        end
      end

      tcw_pkg::S_EXEC: begin
        res_d             = '0;
        res_d.cursor_cell = tcw_pkg::CURSOR_W'(tcw_pkg::cell_of(crow_q, ccol_q));
        state_d           = out_free ? tcw_pkg::S_IDLE : tcw_pkg::S_RESP;
        case (item_q.op)
          tcw_pkg::OP_PUT: begin
            if (oor_q) begin
              mem_we             = 1'b1;
              mem_waddr          = tcw_pkg::CELL_W'(tcw_pkg::CELLS - 1);
              mem_wdata          = {err_attr_q, tcw_pkg::CH_ERROR};
              res_d.out_of_range = 1'b1;
            end else begin
              mem_we    = (item_q.char_code != tcw_pkg::CH_NEWLINE);
              mem_waddr = pos_q;
              mem_wdata = (item_q.char_code == tcw_pkg::CH_BLANK) ?
                          {attr_sel, tcw_pkg::CH_SPACE} : {attr_sel, item_q.char_code};
              crow_d            = nrow;
              ccol_d            = ncol;
              res_d.cursor_cell = tcw_pkg::CURSOR_W'(tcw_pkg::cell_of(nrow, ncol));
              res_d.scrolled    = do_scroll;
              if (do_scroll) begin
                state_d = tcw_pkg::S_SCROLL;
                cnt_d   = '0;
              end
            end
          end
          tcw_pkg::OP_READ: begin
            if (oor_q) begin
              mem_we             = 1'b1;
              mem_waddr          = tcw_pkg::CELL_W'(tcw_pkg::CELLS - 1);
              mem_wdata          = {err_attr_q, tcw_pkg::CH_ERROR};
              res_d.out_of_range = 1'b1;
            end else begin
              res_d.read_char = mem_rdata[tcw_pkg::BYTE_W-1:0];
              res_d.read_attr = mem_rdata[tcw_pkg::CELL_DATA_W-1:tcw_pkg::BYTE_W];
            end
          end
          tcw_pkg::OP_BACKSPACE: begin
            if (bs_act) begin
              mem_we            = 1'b1;
              mem_waddr         = pos_q - 1'b1;
              mem_wdata         = {def_attr_q, tcw_pkg::CH_SPACE};
              crow_d            = bs_row;
              ccol_d            = bs_col;
              res_d.cursor_cell = tcw_pkg::CURSOR_W'(tcw_pkg::cell_of(bs_row, bs_col));
            end
          end
          default: begin
            // clear screen
            crow_d            = '0;
            ccol_d            = '0;
            res_d.cursor_cell = '0;
            cnt_d             = '0;
            state_d           = tcw_pkg::S_BLANK;
          end
        endcase
        if (state_d == tcw_pkg::S_IDLE) begin
          load_out = 1'b1;
        end
      end

      tcw_pkg::S_SCROLL: begin
        // read one row ahead, write back the previous read
        mem_re    = (cnt_q < tcw_pkg::CELL_W'(tcw_pkg::CELLS - tcw_pkg::COLS));
        mem_raddr = cnt_q + tcw_pkg::CELL_W'(tcw_pkg::COLS);
        mem_we    = (cnt_q != '0);
        mem_waddr = cnt_q - 1'b1;
        mem_wdata = mem_rdata;
        if (cnt_q == tcw_pkg::CELL_W'(tcw_pkg::CELLS - tcw_pkg::COLS)) begin
          state_d = tcw_pkg::S_BLANK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      tcw_pkg::S_BLANK: begin
        // fill from cnt up to the last cell
        mem_re    = 1'b0;
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = {def_attr_q, tcw_pkg::CH_SPACE};
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == tcw_pkg::CELL_W'(tcw_pkg::CELLS - 1)) begin
          state_d = tcw_pkg::S_RESP;
        end
      end

      tcw_pkg::S_RESP: begin
        mem_re = 1'b0;
        if (out_free) begin
          load_out = 1'b1;
          state_d  = tcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tcw_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::S_IDLE;
      crow_q      <= '0;
      ccol_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      crow_q  <= crow_d;
      ccol_q  <= ccol_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q <= 8'd244;
      err_attr_q <= 8'd244;
      bs_min_q   <= 7'd9;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.reg_index)
        tcw_pkg::REG_DEFAULT_ATTR: def_attr_q <= cfg.data.value;
        tcw_pkg::REG_ERROR_ATTR:   err_attr_q <= cfg.data.value;
        tcw_pkg::REG_BS_MIN_COL:   bs_min_q   <= cfg.data.value[tcw_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  // command capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= req.data;
      prow_q <= in_row;
      pcol_q <= in_col;
      pos_q  <= in_cell;
      oor_q  <= in_oor;
    end
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_d;
    end
  end

  tcw_ram #(
    .DEPTH (tcw_pkg::CELLS),
    .WIDTH (tcw_pkg::CELL_DATA_W)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
